// ===== src/ludps_pkg.sv =====
// Package for the LU solver: widths, codes, fixed-point helpers.
// No dependencies.
package ludps_pkg;
	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int IW        = $clog2(DIM);
	localparam int EW        = $clog2(DIM * DIM);

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_NOFACT   = 2'd2;

	localparam logic KIND_MAT = 1'b0;
	localparam logic KIND_RHS = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  status;
		logic [31:0] value_res;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_STORE_MAT,
		OP_STORE_RHS,
		OP_DECOMPOSE,
		OP_SOLVE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
		logic [EW-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic ok;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// ===== src/ludps_if.sv =====
// Valid/ready channel interface.
// No dependencies.
interface ludps_if #(parameter int W = 1) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/ludps_div.sv =====
// Iterative fixed-point divider, one quotient bit per cycle, saturated result.
// Depends on ludps_pkg.
module ludps_div import ludps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	localparam int NW = 32 + FRAC_BITS;
	logic [NW-1:0] rem_q, dvd_q;
	logic [31:0]   dsr_q;
	logic          neg_q, zero_q, run_q;
	logic [$clog2(NW+1)-1:0] cnt_q;
	logic [NW:0]   trial;
	logic signed [NW+1:0] sq;

	assign trial = {rem_q, dvd_q[NW-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				cnt_q  <= ($clog2(NW+1))'(NW);
				rem_q  <= '0;
				dvd_q  <= NW'(num[31] ? -{{FRAC_BITS{1'b0}}, 33'(num)} : NW'(num))
				          << FRAC_BITS;
				dsr_q  <= den[31] ? 32'(-33'(den)) : den;
				neg_q  <= num[31] ^ den[31];
				zero_q <= (den == 0);
			end else if (run_q) begin
				if (trial >= {{(NW-31){1'b0}}, dsr_q}) begin
					rem_q <= NW'(trial - {{(NW-31){1'b0}}, dsr_q});
					dvd_q <= {dvd_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial[NW-1:0];
					dvd_q <= {dvd_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end
	always_comb begin
		sq  = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
		quo = zero_q ? 32'sd0 : sat32(66'(sq));
	end
endmodule

// ===== src/ludps_dp.sv =====
// Datapath: matrix and vector stores, pivot search, elimination, substitution.
// Depends on ludps_pkg and ludps_div.
module ludps_dp import ludps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [IW-1:0] rd_idx,
	output logic [31:0] sol
);
	typedef enum logic [3:0] {
		D_IDLE, D_PIV, D_PIVEND, D_SWAP, D_MDIV, D_MWAIT, D_ELIM, D_ELIM2,
		D_FWD, D_FWD2, D_BWD, D_BWD2, D_BDIV, D_BWAIT
	} dst_t;
	dst_t st_q;

	logic signed [31:0] a_q [DIM*DIM];
	logic [IW-1:0]      perm_q [DIM];
	logic signed [31:0] b_q [DIM];
	logic signed [31:0] w_q [DIM];
	logic [IW:0] k_q, i_q, j_q, prow_q;
	logic [31:0] best_q, m_q;
	logic signed [63:0] prod_s1;
	logic signed [65:0] sum_q;
	logic done_q, ok_q;
	logic div_start;
	logic signed [31:0] div_n, div_d, div_q;
	logic div_done;
	logic signed [31:0] num_q, den_q;

	function automatic logic [EW-1:0] ix(input logic [IW:0] r, input logic [IW:0] c);
		return EW'(r[IW-1:0]) * EW'(DIM) + EW'(c[IW-1:0]);
	endfunction

	logic [31:0] mg;
	logic signed [31:0] ea, eb;
	logic signed [63:0] rnd;
	always_comb begin
		mg  = a_q[ix(i_q, k_q)][31] ? 32'(-a_q[ix(i_q, k_q)]) : a_q[ix(i_q, k_q)];
		ea  = (st_q == D_ELIM) ? m_q : a_q[ix(i_q, j_q)];
		eb  = (st_q == D_ELIM) ? a_q[ix(k_q, j_q)] : w_q[j_q[IW-1:0]];
		rnd = (prod_s1 + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	end

	assign div_start = (st_q == D_MDIV) || (st_q == D_BDIV);
	assign div_n = num_q;
	assign div_d = den_q;
	ludps_div u_div (.clk, .arst_n, .start(div_start), .num(div_n), .den(div_d),
		.done(div_done), .quo(div_q));

	assign stat.busy = (st_q != D_IDLE);
	assign stat.done = done_q;
	assign stat.ok   = ok_q;
	assign sol = w_q[rd_idx];

	always_ff @(posedge clk) begin
		if (cmd.op == OP_STORE_MAT) a_q[cmd.idx] <= cmd.value;
		if (cmd.op == OP_STORE_RHS) b_q[cmd.idx[IW-1:0]] <= cmd.value;
		case (st_q)
			D_SWAP: begin
				a_q[ix(k_q, j_q)]    <= a_q[ix(prow_q, j_q)];
				a_q[ix(prow_q, j_q)] <= a_q[ix(k_q, j_q)];
			end
			D_MWAIT: if (div_done) a_q[ix(i_q, k_q)] <= div_q;
			D_ELIM2: a_q[ix(i_q, j_q)] <= sat32(66'(a_q[ix(i_q, j_q)]) - 66'(rnd));
			default: ;
		endcase
		prod_s1 <= ea * eb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
			for (int n = 0; n < DIM; n++) perm_q[n] <= IW'(n);
			k_q <= '0; i_q <= '0; j_q <= '0; prow_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (cmd.op == OP_DECOMPOSE) begin
						for (int n = 0; n < DIM; n++) perm_q[n] <= IW'(n);
						k_q <= '0; i_q <= '0; best_q <= '0; prow_q <= '0;
						st_q <= D_PIV;
					end else if (cmd.op == OP_SOLVE) begin
						i_q <= '0; j_q <= '0; sum_q <= '0;
						st_q <= D_FWD;
					end
				end
				D_PIV: begin
					if (mg > best_q) begin
						best_q <= mg;
						prow_q <= i_q;
					end
					if (i_q == (IW+1)'(DIM-1)) st_q <= D_PIVEND;
					else i_q <= i_q + 1'b1;
				end
				D_PIVEND: begin
					if (best_q == 0) begin
						ok_q <= 1'b0; done_q <= 1'b1; st_q <= D_IDLE;
					end else begin
						j_q <= '0;
						if (prow_q != k_q) begin
							perm_q[k_q[IW-1:0]]    <= perm_q[prow_q[IW-1:0]];
							perm_q[prow_q[IW-1:0]] <= perm_q[k_q[IW-1:0]];
							st_q <= D_SWAP;
						end else if (k_q == (IW+1)'(DIM-1)) begin
							ok_q <= 1'b1; done_q <= 1'b1; st_q <= D_IDLE;
						end else begin
							i_q <= k_q + 1'b1;
							num_q <= a_q[ix(k_q + 1'b1, k_q)];
							den_q <= a_q[ix(k_q, k_q)];
							st_q <= D_MDIV;
						end
					end
				end
				D_SWAP: begin
					if (j_q == (IW+1)'(DIM-1)) begin
						if (k_q == (IW+1)'(DIM-1)) begin
							ok_q <= 1'b1; done_q <= 1'b1; st_q <= D_IDLE;
						end else begin
							i_q <= k_q + 1'b1;
							st_q <= D_MDIV;
							num_q <= a_q[ix(k_q + 1'b1, k_q)];
							den_q <= a_q[ix(k_q, k_q)];
						end
					end
					j_q <= j_q + 1'b1;
				end
				D_MDIV: st_q <= D_MWAIT;
				D_MWAIT: if (div_done) begin
					m_q <= div_q;
					j_q <= k_q + 1'b1;
					st_q <= D_ELIM;
				end
				D_ELIM: st_q <= D_ELIM2;
				D_ELIM2: begin
					if (j_q == (IW+1)'(DIM-1)) begin
						if (i_q == (IW+1)'(DIM-1)) begin
							k_q <= k_q + 1'b1;
							i_q <= k_q + 1'b1;
							best_q <= '0;
							prow_q <= k_q + 1'b1;
							st_q <= D_PIV;
						end else begin
							i_q <= i_q + 1'b1;
							num_q <= a_q[ix(i_q + 1'b1, k_q)];
							den_q <= a_q[ix(k_q, k_q)];
							st_q <= D_MDIV;
						end
					end else begin
						j_q <= j_q + 1'b1;
						st_q <= D_ELIM;
					end
				end
				D_FWD: begin
					if (j_q == i_q) begin
						w_q[i_q[IW-1:0]] <= sat32(66'(b_q[perm_q[i_q[IW-1:0]]]) - sum_q);
						sum_q <= '0;
						if (i_q == (IW+1)'(DIM-1)) begin
							j_q <= (IW+1)'(DIM);
							st_q <= D_BWD;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= '0;
						end
					end else st_q <= D_FWD2;
				end
				D_FWD2: begin
					sum_q <= sum_q + 66'(rnd);
					j_q <= j_q + 1'b1;
					st_q <= D_FWD;
				end
				D_BWD: begin
					if (j_q == (IW+1)'(DIM)) begin
						num_q <= sat32(66'(w_q[i_q[IW-1:0]]) - sum_q);
						den_q <= a_q[ix(i_q, i_q)];
						st_q <= D_BDIV;
					end else st_q <= D_BWD2;
				end
				D_BWD2: begin
					sum_q <= sum_q + 66'(rnd);
					j_q <= j_q + 1'b1;
					st_q <= D_BWD;
				end
				D_BDIV: st_q <= D_BWAIT;
				D_BWAIT: if (div_done) begin
					w_q[i_q[IW-1:0]] <= div_q;
					sum_q <= '0;
					if (i_q == '0) begin
						ok_q <= 1'b1; done_q <= 1'b1; st_q <= D_IDLE;
					end else begin
						i_q <= i_q - 1'b1;
						j_q <= i_q;
						st_q <= D_BWD;
					end
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end
endmodule

// ===== src/ludps_ctrl.sv =====
// Controller: input counters, command issue, result sequencing.
// Depends on ludps_pkg.
module ludps_ctrl import ludps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_item_t      in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_item_t     out_data,
	output dp_cmd_t       cmd,
	input  dp_stat_t      stat,
	output logic [IW-1:0] rd_idx,
	input  logic [31:0]   sol
);
	typedef enum logic [2:0] {S_IN, S_DEC, S_SOL, S_WAIT, S_EMIT} state_t;
	state_t st_q;
	logic [EW-1:0] lcnt_q;
	logic [IW-1:0] rcnt_q, ecnt_q;
	logic fvalid_q, xfer, oxfer, solving_q;

	assign in_ready = (st_q == S_IN) && !out_valid;
	assign xfer  = in_valid && in_ready;
	assign oxfer = out_valid && out_ready;
	assign rd_idx = ecnt_q;

	always_comb begin
		cmd = '{op: OP_NONE, value: in_data.value, idx: lcnt_q};
		if (xfer) begin
			cmd.op = (in_data.kind == KIND_MAT) ? OP_STORE_MAT : OP_STORE_RHS;
			if (in_data.kind == KIND_RHS) cmd.idx = EW'(rcnt_q);
		end
		if (st_q == S_DEC) cmd.op = OP_DECOMPOSE;
		if (st_q == S_SOL) cmd.op = OP_SOLVE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IN; lcnt_q <= '0; rcnt_q <= '0; ecnt_q <= '0;
			fvalid_q <= 1'b0; out_valid <= 1'b0; solving_q <= 1'b0;
			out_data <= '0;
		end else begin
			if (oxfer) out_valid <= 1'b0;
			case (st_q)
				S_IN: if (xfer) begin
					if (in_data.kind == KIND_MAT) begin
						if (lcnt_q == '0) fvalid_q <= 1'b0;
						lcnt_q <= lcnt_q + 1'b1;
						if (lcnt_q == EW'(DIM*DIM-1)) st_q <= S_DEC;
					end else begin
						rcnt_q <= rcnt_q + 1'b1;
						if (rcnt_q == IW'(DIM-1)) begin
							if (fvalid_q) st_q <= S_SOL;
							else begin
								out_valid <= 1'b1;
								out_data <= '{result_kind: 1'b0, status: ST_NOFACT,
									value_res: '0, last: 1'b1};
							end
						end
					end
				end
				S_DEC: begin solving_q <= 1'b0; st_q <= S_WAIT; end
				S_SOL: begin solving_q <= 1'b1; st_q <= S_WAIT; end
				S_WAIT: if (stat.done) begin
					if (solving_q) begin
						ecnt_q <= '0;
						st_q <= S_EMIT;
					end else begin
						fvalid_q <= stat.ok;
						out_valid <= 1'b1;
						out_data <= '{result_kind: 1'b0,
							status: stat.ok ? ST_OK : ST_SINGULAR, value_res: '0, last: 1'b1};
						st_q <= S_IN;
					end
				end
				S_EMIT: if (!out_valid || oxfer) begin
					out_valid <= 1'b1;
					out_data <= '{result_kind: 1'b1, status: ST_OK,
						value_res: sol, last: ecnt_q == IW'(DIM-1)};
					ecnt_q <= ecnt_q + 1'b1;
					if (ecnt_q == IW'(DIM-1)) st_q <= S_IN;
				end
				default: st_q <= S_IN;
			endcase
		end
	end
endmodule

// ===== src/lu_decompose_pivot_solve.sv =====
// Top level of the LU solver with partial pivoting.
// Depends on ludps_pkg, ludps_if, ludps_ctrl, ludps_dp.
// Usage: the in channel carries {kind, value}. DIM*DIM matrix elements (kind 0),
// row-major, start a factorisation on the last element; one status result
// follows (ok or singular). DIM right-hand-side elements (kind 1) start a
// solve; DIM solution elements follow, the last one marked, or one status
// result when no valid factorisation is held.
// A plain load item is stored as it is accepted. Factorisation is set by the
// elimination sequence: a registered multiply then a subtract per element, and a
// serial divide per multiplier. A solve steps through the substitution products
// and DIM serial divides, then emits the solution elements one by one as the
// receiver takes them.
// One item is worked on at a time; input is held off while a run is busy or a
// result waits. A stalled receiver holds the output register and its payload.
// Reset clears counters, the permutation and the valid flag.
module lu_decompose_pivot_solve import ludps_pkg::*; (
	input logic clk,
	input logic arst_n,
	ludps_if.sink   in_ch,
	ludps_if.source out_ch
);
	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [IW-1:0] rd_idx;
	logic [31:0]   sol;
	out_item_t     od;
	in_item_t      id;

	assign id = in_item_t'(in_ch.data);
	ludps_ctrl u_ctrl (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_data(id), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_data(od), .cmd, .stat, .rd_idx, .sol);
	ludps_dp u_dp (.clk, .arst_n, .cmd, .stat, .rd_idx, .sol);
	assign out_ch.data = od;
endmodule

// ===== tb/lu_solve_checker.sv =====
// Checker for the LU solver: watches both channels, predicts every result from
// the accepted input transfers and compares them. Depends on ludps_pkg.
module lu_solve_checker import ludps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [32:0] in_data,
	input logic out_valid,
	input logic out_ready,
	input logic [35:0] out_data,
	output int fail_count,
	output int pending,
	output int solves_seen,
	output int factors_seen
);
	longint lu_mat[DIM*DIM];
	int unsigned perm[DIM];
	longint rhs_vec[DIM];
	longint sol_vec[DIM];
	int unsigned mat_cnt;
	int unsigned rhs_cnt;
	bit lu_ok;
	out_item_t expected_q[$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint qdiv(longint n, longint d);
		if (d == 0) return 0;
		return clamp32((n * (longint'(1) <<< FRAC_BITS)) / d);
	endfunction

	function automatic longint magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit factorise();
		longint best, m, t;
		int unsigned prow, tp;
		for (int i = 0; i < DIM; i++) perm[i] = i;
		for (int k = 0; k < DIM; k++) begin
			best = 0;
			prow = k;
			for (int i = k; i < DIM; i++) begin
				if (magn(lu_mat[i*DIM+k]) > best) begin
					best = magn(lu_mat[i*DIM+k]);
					prow = i;
				end
			end
			if (best == 0) return 0;
			if (prow != k) begin
				tp = perm[k];
				perm[k] = perm[prow];
				perm[prow] = tp;
				for (int j = 0; j < DIM; j++) begin
					t = lu_mat[k*DIM+j];
					lu_mat[k*DIM+j] = lu_mat[prow*DIM+j];
					lu_mat[prow*DIM+j] = t;
				end
			end
			for (int i = k + 1; i < DIM; i++) begin
				m = qdiv(lu_mat[i*DIM+k], lu_mat[k*DIM+k]);
				lu_mat[i*DIM+k] = m;
				for (int j = k + 1; j < DIM; j++)
					lu_mat[i*DIM+j] = clamp32(lu_mat[i*DIM+j] - qmul(m, lu_mat[k*DIM+j]));
			end
		end
		return 1;
	endfunction

	function automatic void substitute();
		longint acc;
		for (int i = 0; i < DIM; i++) begin
			acc = 0;
			for (int j = 0; j < i; j++) acc += qmul(lu_mat[i*DIM+j], sol_vec[j]);
			sol_vec[i] = clamp32(rhs_vec[perm[i]] - acc);
		end
		for (int i = DIM - 1; i >= 0; i--) begin
			acc = 0;
			for (int j = i + 1; j < DIM; j++) acc += qmul(lu_mat[i*DIM+j], sol_vec[j]);
			sol_vec[i] = qdiv(clamp32(sol_vec[i] - acc), lu_mat[i*DIM+i]);
		end
	endfunction

	function automatic void predict(in_item_t it);
		out_item_t r;
		longint v;
		v = longint'($signed(it.value));
		if (it.kind == KIND_MAT) begin
			if (mat_cnt == 0) lu_ok = 0;
			lu_mat[mat_cnt] = v;
			mat_cnt++;
			if (mat_cnt < DIM*DIM) return;
			mat_cnt = 0;
			lu_ok = factorise();
			r = '{1'b0, lu_ok ? ST_OK : ST_SINGULAR, 32'd0, 1'b1};
			expected_q.push_back(r);
			factors_seen++;
		end else begin
			rhs_vec[rhs_cnt] = v;
			rhs_cnt++;
			if (rhs_cnt < DIM) return;
			rhs_cnt = 0;
			solves_seen++;
			if (!lu_ok) begin
				r = '{1'b0, ST_NOFACT, 32'd0, 1'b1};
				expected_q.push_back(r);
				return;
			end
			substitute();
			for (int i = 0; i < DIM; i++) begin
				r = '{1'b1, ST_OK, sol_vec[i][31:0], i == DIM - 1};
				expected_q.push_back(r);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t got, exp_r;
		if (!arst_n) begin
			mat_cnt = 0;
			rhs_cnt = 0;
			lu_ok = 0;
			fail_count = 0;
			pending = 0;
			solves_seen = 0;
			factors_seen = 0;
			for (int i = 0; i < DIM; i++) perm[i] = i;
			expected_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = out_data;
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer %h", got);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (got.result_kind !== exp_r.result_kind) begin
						$error("result_kind: expected %0d, got %0d", exp_r.result_kind,
							got.result_kind);
						fail_count++;
					end
					if (got.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, got.status);
						fail_count++;
					end
					if (got.value_res !== exp_r.value_res) begin
						$error("value_res: expected %h, got %h", exp_r.value_res,
							got.value_res);
						fail_count++;
					end
					if (got.last !== exp_r.last) begin
						$error("last: expected %0d, got %0d", exp_r.last, got.last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) predict(in_data);
			pending = expected_q.size();
		end
	end
endmodule

// ===== tb/lu_decompose_pivot_solve_tb.sv =====
// Testbench top for the LU solver: drives matrices and right-hand sides with
// random idling and gives the verdict. Depends on ludps_pkg, ludps_if, lu_solve_checker.
module lu_decompose_pivot_solve_tb;
	import ludps_pkg::*;

	logic clk;
	logic arst_n;
	int fail_count, pending, solves_seen, factors_seen;
	int src_idle, snk_stall;
	int items_sent;

	ludps_if #(.W(33)) in_ch (clk);
	ludps_if #(.W(36)) out_ch (clk);

	lu_decompose_pivot_solve dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	lu_solve_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.fail_count(fail_count),
		.pending(pending),
		.solves_seen(solves_seen),
		.factors_seen(factors_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#30000000;
		$display("Test completed with failures");
		$finish;
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= snk_stall);
	end

	task automatic send(input logic kind, input logic [31:0] value);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= {kind, value};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [31:0] rand_elem(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
			2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'd0;
		endcase
	endfunction

	task automatic send_matrix(input int kindsel);
		logic [31:0] v;
		for (int i = 0; i < DIM*DIM; i++) begin
			case (kindsel)
				0: v = rand_elem($urandom_range(9) < 7 ? 1 : $urandom_range(3));
				1: v = (i / DIM == i % DIM) ? 32'h0001_0000 : 32'd0;
				2: v = (i % DIM == 0) ? 32'd0 : rand_elem(1);
				3: v = rand_elem(2);
				default: v = (i / DIM == 1) ? 32'd0 : rand_elem(1);
			endcase
			send(KIND_MAT, v);
		end
	endtask

	task automatic send_rhs();
		for (int i = 0; i < DIM; i++)
			send(KIND_RHS, rand_elem($urandom_range(9) < 7 ? 1 : $urandom_range(3)));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int r;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		src_idle = 0;
		snk_stall = 0;
		items_sent = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_rhs();
		send_matrix(1);
		send_rhs();
		send_matrix(2);
		send_rhs();
		send_matrix(3);
		send_rhs();
		send_matrix(4);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			src_idle = (phase == 1 || phase == 3) ? 66 : 0;
			snk_stall = (phase == 2 || phase == 3) ? 66 : 0;
			if (phase == 3) begin
				src_idle = 6;
				snk_stall = 6;
			end
			repeat (3) begin
				r = $urandom_range(19);
				if (r < 14) begin
					send_matrix(r < 12 ? 0 : 3);
					repeat ($urandom_range(1, 3)) send_rhs();
				end else if (r < 16) begin
					send_matrix(2 + $urandom_range(2));
					send_rhs();
				end else begin
					send(KIND_RHS, rand_elem(0));
					send(KIND_MAT, rand_elem(1));
					send(KIND_RHS, rand_elem(1));
				end
			end
			drain();
		end
		src_idle = 0;
		snk_stall = 0;
		while (items_sent < 310) begin
			send_matrix(0);
			send_rhs();
		end
		drain();
		repeat (600) @(negedge clk);

		$display("Covered %0d input transfers, %0d factorisations, %0d solves.",
			items_sent, factors_seen, solves_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
src/ludps_pkg.sv
src/ludps_if.sv
src/ludps_div.sv
src/ludps_dp.sv
src/ludps_ctrl.sv
src/lu_decompose_pivot_solve.sv
tb/lu_solve_checker.sv
tb/lu_decompose_pivot_solve_tb.sv
